FILE: design/rde_pkg.sv
// Shared constants, codes and controller/datapath types of the rectangle draw engine.
`timescale 1ns / 1ps

package rde_pkg;

  // Screen geometry
  localparam int COLS = 640;
  localparam int ROWS = 400;
  localparam int STORE_DEPTH = COLS * ROWS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Item field widths
  localparam int OP_W     = 3;
  localparam int XY_W     = 10;
  localparam int COLOUR_W = 8;

  localparam logic [XY_W:0]   COLS_EXT = (XY_W + 1)'(COLS);
  localparam logic [XY_W:0]   ROWS_EXT = (XY_W + 1)'(ROWS);
  localparam logic [XY_W-1:0] LAST_COL = XY_W'(COLS - 1);
  localparam logic [XY_W-1:0] LAST_ROW = XY_W'(ROWS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_OUTLINE     = 3'd0,
    OP_SOLID       = 3'd1,
    OP_TRANSLUCENT = 3'd2,
    OP_READ        = 3'd3,
    OP_CLEAR       = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted command item
    logic load_clear;  // set up a whole-screen clear (reset sweep)
    logic setup;       // walker to the start corner
    logic walk;        // one pixel step, write if selected
    logic rd;          // read the store at the walker address
    logic emit;        // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    bad;      // start corner or read position off screen
    logic    last;     // walker sits on the far corner
  } dp_status_t;

endpackage

FILE: design/rectangle_draw_engine.sv
// Top level of the rectangle draw engine: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

// Rectangle draw engine over a byte-per-pixel frame store of COLS x ROWS
// pixels (raster order, address = row * COLS + column). Each command item
// carries an opcode in tuser and two corners plus a colour in tdata; the
// engine orders the corners, clips the far one to the last column and row,
// and draws an outline, a solid fill or a translucent fill (every second
// pixel in raster order over the whole rectangle), reads one pixel, or
// clears the store. Every command gives exactly one result item: a status
// flag in tuser (set when the start corner or read position is off screen,
// nothing drawn) and the read pixel in tdata (zero for other commands).
// Timing: commands run one at a time. A draw walks every pixel of the
// clipped rectangle through a single store write port, one pixel a cycle.
// After reset the engine clears the store itself, with s_axis_tready
// low. A new command is taken as soon as the previous result sits in
// the output register, even before it is taken.
module rectangle_draw_engine import rde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_first[9:0], y_first[19:10], x_second[29:20], y_second[39:30], colour[47:40]
  input  logic [47:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel[7:0]
  output logic [7:0]  m_axis_tdata,
  // status[0]
  output logic        m_axis_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rde_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .opcode_i     (s_axis_tuser),
    .x_first_i    (s_axis_tdata[9:0]),
    .y_first_i    (s_axis_tdata[19:10]),
    .x_second_i   (s_axis_tdata[29:20]),
    .y_second_i   (s_axis_tdata[39:30]),
    .colour_i     (s_axis_tdata[47:40]),
    .status_o     (status),
    .res_status_o (m_axis_tuser),
    .res_pixel_o  (m_axis_tdata)
  );

endmodule

FILE: design/rde_ctrl.sv
// Command sequencer of the rectangle draw engine.
`timescale 1ns / 1ps

module rde_ctrl import rde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   silent_q, silent_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      silent_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      silent_q    <= silent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    silent_d = silent_q;
    case (state_q)
      ST_INIT: begin
        state_d  = ST_SETUP;
        silent_d = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d  = ST_SETUP;
          silent_d = 1'b0;
        end
      end
      ST_SETUP: begin
        case (status_i.op)
          OP_OUTLINE, OP_SOLID, OP_TRANSLUCENT: state_d = status_i.bad ? ST_DONE : ST_WALK;
          OP_READ:  state_d = status_i.bad ? ST_DONE : ST_READ;
          OP_CLEAR: state_d = ST_WALK;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_WALK: begin
        if (status_i.last) state_d = silent_q ? ST_IDLE : ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: cmd_o.load_clear = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_WALK:  cmd_o.walk  = 1'b1;
      ST_READ:  cmd_o.rd    = 1'b1;
      ST_DONE:  cmd_o.emit  = out_free;
      default:  cmd_o       = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.emit)  out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/rde_datapath.sv
// Corner ordering, pixel walker, frame store and result register.
`timescale 1ns / 1ps

module rde_datapath import rde_pkg::*; (
  input  logic                clk_i,
  input  dp_cmd_t             cmd_i,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [XY_W-1:0]     x_first_i,
  input  logic [XY_W-1:0]     y_first_i,
  input  logic [XY_W-1:0]     x_second_i,
  input  logic [XY_W-1:0]     y_second_i,
  input  logic [COLOUR_W-1:0] colour_i,
  output dp_status_t          status_o,
  output logic                res_status_o,
  output logic [COLOUR_W-1:0] res_pixel_o
);

  // Frame store
  logic [COLOUR_W-1:0] store_q [STORE_DEPTH];

  opcode_e             op_q, op_d;
  logic                bad_q, bad_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic [XY_W-1:0]     x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic [XY_W-1:0]     col_q, col_d, row_q, row_d;
  logic [ADDR_W-1:0]   addr_q, addr_d, line_q, line_d;
  logic                parity_q, parity_d;
  logic [COLOUR_W-1:0] rd_q;
  logic                res_status_q;
  logic [COLOUR_W-1:0] res_pixel_q;

  logic [XY_W-1:0]     xlo, xhi, ylo, yhi;
  logic [ADDR_W-1:0]   corner_addr, next_line;
  logic                row_end, sel, wr_en;

  // Order the corners per axis, then clip the far corner
  always_comb begin
    xlo = (x_first_i > x_second_i) ? x_second_i : x_first_i;
    xhi = (x_first_i > x_second_i) ? x_first_i  : x_second_i;
    ylo = (y_first_i > y_second_i) ? y_second_i : y_first_i;
    yhi = (y_first_i > y_second_i) ? y_first_i  : y_second_i;
    if ({1'b0, xhi} >= COLS_EXT) xhi = LAST_COL;
    if ({1'b0, yhi} >= ROWS_EXT) yhi = LAST_ROW;
  end

  always_comb begin
    op_d     = op_q;
    colour_d = colour_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y0_d     = y0_q;
    y1_d     = y1_q;
    bad_d    = bad_q;
    if (cmd_i.load_clear || (cmd_i.load && opcode_e'(opcode_i) == OP_CLEAR)) begin
      op_d     = OP_CLEAR;
      colour_d = '0;
      x0_d     = '0;
      y0_d     = '0;
      x1_d     = LAST_COL;
      y1_d     = LAST_ROW;
      bad_d    = 1'b0;
    end else if (cmd_i.load) begin
      op_d     = opcode_e'(opcode_i);
      colour_d = colour_i;
      if (opcode_e'(opcode_i) == OP_READ) begin
        x0_d = x_first_i;
        y0_d = y_first_i;
      end else begin
        x0_d = xlo;
        y0_d = ylo;
      end
      x1_d  = xhi;
      y1_d  = yhi;
      bad_d = ({1'b0, x0_d} >= COLS_EXT) || ({1'b0, y0_d} >= ROWS_EXT);
    end
  end

  // Walker: raster scan with an incremental address
  assign corner_addr = ADDR_W'(y0_q) * ADDR_W'(COLS) + ADDR_W'(x0_q);
  assign next_line   = line_q + ADDR_W'(COLS);
  assign row_end     = (col_q == x1_q);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    addr_d   = addr_q;
    line_d   = line_q;
    parity_d = parity_q;
    if (cmd_i.setup) begin
      col_d    = x0_q;
      row_d    = y0_q;
      addr_d   = corner_addr;
      line_d   = corner_addr;
      parity_d = 1'b0;
    end else if (cmd_i.walk) begin
      parity_d = !parity_q;
      if (row_end) begin
        col_d  = x0_q;
        row_d  = row_q + 1'b1;
        line_d = next_line;
        addr_d = next_line;
      end else begin
        col_d  = col_q + 1'b1;
        addr_d = addr_q + 1'b1;
      end
    end
  end

  // Which pixels of the rectangle are written
  always_comb begin
    case (op_q)
      OP_OUTLINE:     sel = (row_q == y0_q) || (row_q == y1_q) ||
                            (col_q == x0_q) || (col_q == x1_q);
      OP_SOLID:       sel = 1'b1;
      OP_TRANSLUCENT: sel = parity_q;
      OP_CLEAR:       sel = 1'b1;
      default:        sel = 1'b0;
    endcase
  end

  assign wr_en = cmd_i.walk && sel;

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[addr_q] <= colour_q;
    if (cmd_i.rd) rd_q <= store_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    bad_q    <= bad_d;
    colour_q <= colour_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    col_q    <= col_d;
    row_q    <= row_d;
    addr_q   <= addr_d;
    line_q   <= line_d;
    parity_q <= parity_d;
    if (cmd_i.emit) begin
      res_status_q <= bad_q && (op_q == OP_OUTLINE || op_q == OP_SOLID ||
                                op_q == OP_TRANSLUCENT || op_q == OP_READ);
      res_pixel_q  <= (op_q == OP_READ && !bad_q) ? rd_q : '0;
    end
  end

  assign status_o.op   = op_q;
  assign status_o.bad  = bad_q;
  assign status_o.last = row_end && (row_q == y1_q);
  assign res_status_o  = res_status_q;
  assign res_pixel_o   = res_pixel_q;

endmodule
